### rtl/psm_pkg.sv
package psm_pkg;

  // Coordinate format: signed Q(COORD_W-FRAC_BITS).FRAC_BITS.
  // Spans of COORD_W <= 30 bits stay below 2^31, so no normalization shift is needed.
  localparam int COORD_W    = 24;
  localparam int FRAC_BITS  = 8;
  localparam int THICK_W    = 16;
  localparam int MUL_W      = 16;

  localparam int DELTA_W    = COORD_W + 1;
  localparam int ABS_W      = COORD_W;
  localparam int SQ_W       = 2 * ABS_W + 1;
  localparam int ROOT_W     = ABS_W + 1;
  localparam int SQRT_LAT   = ROOT_W;
  localparam int SQRT_PAD_W = 2 * SQRT_LAT;
  localparam int REM_W      = ROOT_W + 3;

  localparam int UNIT_SHIFT = 30;
  localparam int QUO_W      = UNIT_SHIFT + 1;
  localparam int DIV_LAT    = QUO_W;

  localparam int KPROD_W    = THICK_W + MUL_W + 1;
  localparam int KABS_W     = THICK_W + MUL_W - 1;
  localparam int PROD_W     = KABS_W + QUO_W;
  localparam int OFF_SHIFT  = 45 - FRAC_BITS;
  localparam int M_W        = PROD_W - OFF_SHIFT;
  localparam int OFF_W      = M_W + 1;
  localparam int FIN_W      = ((OFF_W > DELTA_W) ? OFF_W : DELTA_W) + 2;

  localparam int DL_LEN     = SQRT_LAT + DIV_LAT;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic        [THICK_W-1:0] thickness;
    logic signed [MUL_W-1:0]   multiplier;
  } psm_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic                      degenerate;
    logic                      saturated;
  } psm_out_t;

  // Per-transaction sideband that rides alongside the sqrt and divide pipes.
  typedef struct packed {
    logic        [ABS_W-1:0]   ax;
    logic        [ABS_W-1:0]   ay;
    logic        [KABS_W-1:0]  kabs;
    logic                      offx_neg;
    logic                      offx_zero;
    logic                      offy_neg;
    logic                      offy_zero;
    logic                      deg;
    logic signed [DELTA_W-1:0] sumx;
    logic signed [DELTA_W-1:0] sumy;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
  } psm_side_t;

endpackage

### rtl/psm_if.sv
interface psm_in_if import psm_pkg::*; ();
  logic    valid;
  logic    ready;
  psm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psm_out_if import psm_pkg::*; ();
  logic     valid;
  logic     ready;
  psm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/psm_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module psm_isqrt import psm_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   radicand,
  output logic [ROOT_W-1:0] root
);

  logic [SQRT_PAD_W-1:0] n_r    [SQRT_LAT-1];
  logic [REM_W-1:0]      rem_r  [SQRT_LAT-1];
  logic [ROOT_W-1:0]     root_r [SQRT_LAT];

  for (genvar i = 0; i < SQRT_LAT; i++) begin : g_step
    logic [SQRT_PAD_W-1:0] n_in;
    logic [REM_W-1:0]      rem_in;
    logic [ROOT_W-1:0]     root_in;
    logic [REM_W+1:0]      trial;
    logic [REM_W+1:0]      test;
    logic [REM_W-1:0]      rem_nxt;
    logic [ROOT_W-1:0]     root_nxt;

    if (i == 0) begin : g_first
      assign n_in    = SQRT_PAD_W'(radicand);
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign n_in    = n_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    always_comb begin
      trial = {rem_in, n_in[SQRT_PAD_W-1-2*i -: 2]};
      test  = (REM_W+2)'({root_in, 2'b01});
      if (trial >= test) begin
        rem_nxt  = REM_W'(trial - test);
        root_nxt = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = REM_W'(trial);
        root_nxt = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[i] <= root_nxt;
      end
    end

    if (i < SQRT_LAT - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          n_r[i]   <= n_in;
          rem_r[i] <= rem_nxt;
        end
      end
    end
  end

  assign root = root_r[SQRT_LAT-1];

endmodule

### rtl/psm_udiv.sv
// Pipelined restoring divider: quo = (num << UNIT_SHIFT) / den, num <= den.
module psm_udiv import psm_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [ABS_W-1:0]  num,
  input  logic [ROOT_W-1:0] den,
  output logic [QUO_W-1:0]  quo
);

  logic [ROOT_W-1:0] rem_r [DIV_LAT-1];
  logic [ROOT_W-1:0] den_r [DIV_LAT-1];
  logic [QUO_W-1:0]  q_r   [DIV_LAT];

  for (genvar j = 0; j < DIV_LAT; j++) begin : g_step
    logic [ROOT_W:0]   trial;
    logic [ROOT_W-1:0] den_in;
    logic [QUO_W-1:0]  q_in;
    logic              ge;
    logic [ROOT_W-1:0] rem_nxt;

    if (j == 0) begin : g_first
      // First step sees the whole numerator; later steps shift in zeros.
      assign trial  = (ROOT_W+1)'(num);
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign trial  = {rem_r[j-1], 1'b0};
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
    end

    always_comb begin
      ge      = (trial >= {1'b0, den_in});
      rem_nxt = ge ? ROOT_W'(trial - {1'b0, den_in}) : ROOT_W'(trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j] <= {q_in[QUO_W-2:0], ge};
      end
    end

    if (j < DIV_LAT - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= rem_nxt;
          den_r[j] <= den_in;
        end
      end
    end
  end

  assign quo = q_r[DIV_LAT-1];

endmodule

### rtl/perpendicular_segment_at_midpoint_unit.sv
// Perpendicular segment through a midpoint.
// in_ch carries one segment per transaction: two points in signed Q16.8, a
// thickness (unsigned Q8.8) and a multiplier (signed Q8.8). out_ch returns
// one transaction per input: the two endpoints of a segment crossing the
// midpoint at a right angle at distance multiplier*thickness on each side,
// plus a degenerate flag (coincident points) and a saturation flag.
// From input acceptance to out_ch.valid a result passes the input register,
// delta/scale, squares, sum of squares, 25 square-root stages, 31 divider
// stages, offset multiply, rounding, then the output register.
// Throughput: one transaction per cycle while the skid is empty; every step
// of the square root and of the unit-vector divide owns its own register stage.
// Reset (rst_n low, synchronous) clears all valid bits; data in flight is lost.
// When the receiver stalls, one more result is caught in a skid register and
// then in_ch.ready drops; the whole pipe holds until the skid drains.
module perpendicular_segment_at_midpoint_unit import psm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  psm_in_if.sink   in_ch,
  psm_out_if.source out_ch
);

  localparam logic signed [FIN_W-1:0] HI_L = FIN_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
  localparam logic signed [FIN_W-1:0] LO_L = -HI_L - FIN_W'(1);
  localparam logic [PROD_W-1:0] ROUND_C = PROD_W'(1) << (OFF_SHIFT - 1);

  logic pipe_en;

  // Stage 1: input register
  logic    v1_r;
  psm_in_t in1_r;

  // Stage 2: deltas, scale, sign decisions
  logic      v2_r;
  psm_side_t side2_r;
  psm_side_t side2_nxt;

  // Stage 3: squares
  logic             v3_r;
  psm_side_t        side3_r;
  logic [SQ_W-2:0]  sqx_r;
  logic [SQ_W-2:0]  sqy_r;

  // Stage 4: sum of squares
  logic            v4_r;
  psm_side_t       side4_r;
  logic [SQ_W-1:0] n4_r;

  // Sideband delay line across the sqrt and divide pipes
  logic      vdl_r   [DL_LEN];
  psm_side_t side_dl_r [DL_LEN];

  logic [ROOT_W-1:0] root;
  logic [ROOT_W-1:0] len;
  logic [QUO_W-1:0]  ux;
  logic [QUO_W-1:0]  uy;

  // Multiply stage
  logic              vm_r;
  psm_side_t         sidem_r;
  logic [PROD_W-1:0] prodx_r;
  logic [PROD_W-1:0] prody_r;

  // Offset stage
  logic                    vr_r;
  psm_side_t               sider_r;
  logic signed [OFF_W-1:0] offx_r;
  logic signed [OFF_W-1:0] offy_r;
  logic [M_W-1:0]          mx;
  logic [M_W-1:0]          my;

  // Output register and skid
  logic     out_v_r;
  psm_out_t out_r;
  logic     skid_v_r;
  psm_out_t skid_r;
  psm_out_t fin;

  // Hold the whole pipe only while the skid is occupied.
  assign pipe_en     = !skid_v_r;
  assign in_ch.ready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vm_r <= 1'b0;
      vr_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      vm_r <= vdl_r[DL_LEN-1];
      vr_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DL_LEN; i++) begin
        vdl_r[i] <= 1'b0;
      end
    end else if (pipe_en) begin
      vdl_r[0] <= v4_r;
      for (int i = 1; i < DL_LEN; i++) begin
        vdl_r[i] <= vdl_r[i-1];
      end
    end
  end

  // Stage 2: differences, k = multiplier * thickness, offset signs.
  always_comb begin
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [DELTA_W-1:0] adx;
    logic signed [DELTA_W-1:0] ady;
    logic signed [KPROD_W-1:0] k;
    logic signed [KPROD_W-1:0] ka;
    logic                      kneg;
    logic                      cross_neg;
    logic                      cross_zero;
    logic                      steep;

    dx  = DELTA_W'(in1_r.end_x) - DELTA_W'(in1_r.start_x);
    dy  = DELTA_W'(in1_r.end_y) - DELTA_W'(in1_r.start_y);
    adx = dx[DELTA_W-1] ? -dx : dx;
    ady = dy[DELTA_W-1] ? -dy : dy;
    k   = $signed({1'b0, in1_r.thickness}) * KPROD_W'(in1_r.multiplier);
    ka  = k[KPROD_W-1] ? -k : k;
    kneg = k[KPROD_W-1];
    // Sign of -k*sign(dx)*sign(dy); zero whenever the segment is axis aligned.
    cross_neg  = !(kneg ^ dx[DELTA_W-1] ^ dy[DELTA_W-1]);
    cross_zero = (dx == '0) || (dy == '0);
    steep      = ady > adx;

    side2_nxt.ax        = ABS_W'(adx);
    side2_nxt.ay        = ABS_W'(ady);
    side2_nxt.kabs      = KABS_W'(ka);
    side2_nxt.offx_neg  = steep ? kneg : cross_neg;
    side2_nxt.offx_zero = steep ? 1'b0 : cross_zero;
    side2_nxt.offy_neg  = steep ? cross_neg : kneg;
    side2_nxt.offy_zero = steep ? cross_zero : 1'b0;
    side2_nxt.deg       = (dx == '0) && (dy == '0);
    side2_nxt.sumx      = DELTA_W'(in1_r.start_x) + DELTA_W'(in1_r.end_x);
    side2_nxt.sumy      = DELTA_W'(in1_r.start_y) + DELTA_W'(in1_r.end_y);
    side2_nxt.sx        = in1_r.start_x;
    side2_nxt.sy        = in1_r.start_y;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      in1_r   <= in_ch.data;
      side2_r <= side2_nxt;
      side3_r <= side2_r;
      sqx_r   <= side2_r.ax * side2_r.ax;
      sqy_r   <= side2_r.ay * side2_r.ay;
      side4_r <= side3_r;
      n4_r    <= SQ_W'(sqx_r) + SQ_W'(sqy_r);
      side_dl_r[0] <= side4_r;
      for (int i = 1; i < DL_LEN; i++) begin
        side_dl_r[i] <= side_dl_r[i-1];
      end
    end
  end

  psm_isqrt u_isqrt (
    .clk      (clk),
    .en       (pipe_en),
    .radicand (n4_r),
    .root     (root)
  );

  // Coincident points give a zero root; keep the divider defined.
  assign len = (root == '0) ? ROOT_W'(1) : root;

  psm_udiv u_div_x (
    .clk (clk),
    .en  (pipe_en),
    .num (side_dl_r[SQRT_LAT-1].ax),
    .den (len),
    .quo (ux)
  );

  psm_udiv u_div_y (
    .clk (clk),
    .en  (pipe_en),
    .num (side_dl_r[SQRT_LAT-1].ay),
    .den (len),
    .quo (uy)
  );

  // Multiply: x offset scales uy, y offset scales ux.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sidem_r <= side_dl_r[DL_LEN-1];
      prodx_r <= side_dl_r[DL_LEN-1].kabs * uy;
      prody_r <= side_dl_r[DL_LEN-1].kabs * ux;
    end
  end

  // Round to half-LSB units and apply signs.
  always_comb begin
    logic [PROD_W-1:0] rx;
    logic [PROD_W-1:0] ry;
    rx = prodx_r + ROUND_C;
    ry = prody_r + ROUND_C;
    mx = M_W'(rx >> OFF_SHIFT);
    my = M_W'(ry >> OFF_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sider_r <= sidem_r;
      if (sidem_r.offx_zero) begin
        offx_r <= '0;
      end else begin
        offx_r <= sidem_r.offx_neg ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
      end
      if (sidem_r.offy_zero) begin
        offy_r <= '0;
      end else begin
        offy_r <= sidem_r.offy_neg ? -$signed({1'b0, my}) : $signed({1'b0, my});
      end
    end
  end

  // Final: midpoint +/- offset, round half up, clamp; degenerate inputs return the start point.
  always_comb begin
    logic signed [FIN_W-1:0]   lane_sum [4];
    logic signed [FIN_W-1:0]   lane_off [4];
    logic signed [FIN_W-1:0]   v;
    logic signed [FIN_W-1:0]   h;
    logic signed [COORD_W-1:0] res [4];
    logic                      sat;

    lane_sum[0] = FIN_W'(sider_r.sumx);
    lane_sum[1] = FIN_W'(sider_r.sumy);
    lane_sum[2] = FIN_W'(sider_r.sumx);
    lane_sum[3] = FIN_W'(sider_r.sumy);
    lane_off[0] = FIN_W'(offx_r);
    lane_off[1] = FIN_W'(offy_r);
    lane_off[2] = -FIN_W'(offx_r);
    lane_off[3] = -FIN_W'(offy_r);
    sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      v = lane_sum[i] + lane_off[i] + FIN_W'(1);
      h = v >>> 1;
      if (h > HI_L) begin
        res[i] = COORD_W'(HI_L);
        sat    = 1'b1;
      end else if (h < LO_L) begin
        res[i] = COORD_W'(LO_L);
        sat    = 1'b1;
      end else begin
        res[i] = COORD_W'(h);
      end
    end

    if (sider_r.deg) begin
      fin.first_x   = sider_r.sx;
      fin.first_y   = sider_r.sy;
      fin.second_x  = sider_r.sx;
      fin.second_y  = sider_r.sy;
      fin.degenerate = 1'b1;
      fin.saturated  = 1'b0;
    end else begin
      fin.first_x   = res[0];
      fin.first_y   = res[1];
      fin.second_x  = res[2];
      fin.second_y  = res[3];
      fin.degenerate = 1'b0;
      fin.saturated  = sat;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= vr_r;
      end
    end else if (pipe_en && vr_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      out_r <= skid_v_r ? skid_r : fin;
    end else if (pipe_en) begin
      skid_r <= fin;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held with empty output register");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && out_ch.ready |=> out_v_r && !skid_v_r)
    else $error("skid entry not moved to output");

  a_stall_catches: assert property (@(posedge clk) disable iff (!rst_n)
    vr_r && !skid_v_r && out_v_r && !out_ch.ready |=> skid_v_r)
    else $error("result dropped during output stall");

  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.degenerate |->
      !out_r.saturated && out_r.first_x == out_r.second_x &&
      out_r.first_y == out_r.second_y)
    else $error("degenerate result with distinct endpoints");
`endif

endmodule
